// ===== src/vgmcbp_pkg.sv =====
`default_nettype none

package vgmcbp_pkg;

    // Parser phases: what the next byte of the stream is taken to be.
    typedef enum logic [3:0] {
        PH_OPCODE,
        PH_ARG31,
        PH_A0_ADDR,
        PH_A0_DATA,
        PH_B4_ADDR,
        PH_B4_DATA,
        PH_W61_LO,
        PH_W61_HI,
        PH_BLK_HDR,
        PH_BLK_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        EV_WRITE   = 2'd0,
        EV_WAIT    = 2'd1,
        EV_END     = 2'd2,
        EV_UNKNOWN = 2'd3
    } event_kind_t;

    // Command opcodes.
    localparam logic [7:0] OP_SKIP_ARG    = 8'h31;
    localparam logic [7:0] OP_WRITE_A     = 8'hA0;
    localparam logic [7:0] OP_WRITE_B     = 8'hB4;
    localparam logic [7:0] OP_WAIT_N      = 8'h61;
    localparam logic [7:0] OP_WAIT_NTSC   = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL    = 8'h63;
    localparam logic [7:0] OP_END         = 8'h66;
    localparam logic [7:0] OP_DATA_BLOCK  = 8'h67;
    localparam logic [3:0] OP_WAIT_SHORT  = 4'h7;

    localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
    localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;

    // Data block header: marker, type, then four length bytes.
    localparam logic [2:0] BLK_LEN_B0   = 3'd2;
    localparam logic [2:0] BLK_LEN_B1   = 3'd3;
    localparam logic [2:0] BLK_LEN_B2   = 3'd4;
    localparam logic [2:0] BLK_LEN_B3   = 3'd5;
    localparam logic [2:0] BLK_HDR_LAST = 3'd5;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  arg_position;
        logic [7:0]  held_address;
        logic [7:0]  held_low_byte;
        logic [31:0] skip_remaining;
        logic        halted;
    } parser_state_t;

    typedef struct packed {
        event_kind_t kind;
        logic        chip_index;
        logic [7:0]  reg_address;
        logic [7:0]  reg_value;
        logic [15:0] wait_samples;
    } parser_result_t;

endpackage

`default_nettype wire

// ===== src/vgm_command_byte_parser_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_ready   stream_byte[7:0]
// output    out        out_valid/out_ready event_kind, chip_index, reg_address,
//                                          reg_value, wait_samples
// config    in         cfg_write_en        cfg_write_data (chip family)
//
// One stream byte is accepted per clock cycle when the output side keeps up.
// A byte is held in the input register and its result, if any, is then
// registered in the result register and shown from there.
// The throughput is set by the parser state register, updated once per item.
// Reset is asynchronous and active low; it clears the parser state, both
// valid flags and the chip family selection.
// A stall on the output holds the result register; the input register still
// takes one more item, after which in_ready falls until the result is taken.
module vgm_command_byte_parser_unit
    import vgmcbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic        chip_index,
    output logic [7:0]  reg_address,
    output logic [7:0]  reg_value,
    output logic [15:0] wait_samples
);

    // Input register stage.
    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;

    // Parser state and configuration.
    parser_state_t  state_reg;
    parser_state_t  state_next;
    logic           family_reg;

    // Result register stage.
    logic           out_valid_reg;
    parser_result_t out_result_reg;

    logic           step_valid;
    parser_result_t step_result;
    logic           advance;

    // The held item moves on when the result register is empty or being
    // emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    vgmcbp_step u_step (
        .state_cur    (state_reg),
        .stream_byte  (in_byte_reg),
        .chip_family  (family_reg),
        .state_next   (state_next),
        .result_valid (step_valid),
        .result       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            family_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= stream_byte;
        end
    end

    // The whole parser state is cleared on reset, including the held bytes
    // and the skip count, since each has a defined starting value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_OPCODE, arg_position: 3'd0, held_address: 8'd0,
                           held_low_byte: 8'd0, skip_remaining: 32'd0, halted: 1'b0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_valid)
        begin
            out_result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = out_result_reg.kind;
    assign chip_index   = out_result_reg.chip_index;
    assign reg_address  = out_result_reg.reg_address;
    assign reg_value    = out_result_reg.reg_value;
    assign wait_samples = out_result_reg.wait_samples;

endmodule

`default_nettype wire

// ===== src/vgmcbp_step.sv =====
`default_nettype none

// Next-state and result logic for one stream byte.
module vgmcbp_step
    import vgmcbp_pkg::*;
(
    input  parser_state_t  state_cur,
    input  logic [7:0]     stream_byte,
    input  logic           chip_family,
    output parser_state_t  state_next,
    output logic           result_valid,
    output parser_result_t result
);

    logic [31:0] skip_new;
    logic [31:0] skip_dec;

    always_comb
    begin
        state_next   = state_cur;
        result_valid = 1'b0;
        result       = '0;
        skip_new     = state_cur.skip_remaining;
        skip_dec     = state_cur.skip_remaining;

        if (!state_cur.halted)
        begin
            unique case (state_cur.phase)
                PH_ARG31:
                begin
                    state_next.phase = PH_OPCODE;
                end
                PH_A0_ADDR:
                begin
                    state_next.held_address = stream_byte;
                    state_next.phase        = PH_A0_DATA;
                end
                PH_A0_DATA:
                begin
                    state_next.phase = PH_OPCODE;
                    if (chip_family == 1'b0)
                    begin
                        result_valid       = 1'b1;
                        result.kind        = EV_WRITE;
                        result.chip_index  = state_cur.held_address[7];
                        result.reg_address = {1'b0, state_cur.held_address[6:0]};
                        result.reg_value   = stream_byte;
                    end
                end
                PH_B4_ADDR:
                begin
                    state_next.held_address = stream_byte;
                    state_next.phase        = PH_B4_DATA;
                end
                PH_B4_DATA:
                begin
                    state_next.phase = PH_OPCODE;
                    if (chip_family == 1'b1)
                    begin
                        result_valid       = 1'b1;
                        result.kind        = EV_WRITE;
                        result.reg_address = state_cur.held_address;
                        result.reg_value   = stream_byte;
                    end
                end
                PH_W61_LO:
                begin
                    state_next.held_low_byte = stream_byte;
                    state_next.phase         = PH_W61_HI;
                end
                PH_W61_HI:
                begin
                    state_next.phase = PH_OPCODE;
                    // A zero count is dropped silently.
                    if ({stream_byte, state_cur.held_low_byte} != 16'd0)
                    begin
                        result_valid        = 1'b1;
                        result.kind         = EV_WAIT;
                        result.wait_samples = {stream_byte, state_cur.held_low_byte};
                    end
                end
                PH_BLK_HDR:
                begin
                    // The length was cleared at the opcode, so each byte lane
                    // is simply loaded once.
                    unique case (state_cur.arg_position)
                        BLK_LEN_B0: skip_new[7:0]   = stream_byte;
                        BLK_LEN_B1: skip_new[15:8]  = stream_byte;
                        BLK_LEN_B2: skip_new[23:16] = stream_byte;
                        BLK_LEN_B3: skip_new[31:24] = stream_byte;
                        default:    skip_new        = state_cur.skip_remaining;
                    endcase
                    state_next.skip_remaining = skip_new;
                    if (state_cur.arg_position >= BLK_HDR_LAST)
                    begin
                        state_next.arg_position = 3'd0;
                        state_next.phase = (skip_new == 32'd0) ? PH_OPCODE : PH_BLK_SKIP;
                    end
                    else
                    begin
                        state_next.arg_position = state_cur.arg_position + 3'd1;
                    end
                end
                PH_BLK_SKIP:
                begin
                    if (state_cur.skip_remaining != 32'd0)
                    begin
                        skip_dec = state_cur.skip_remaining - 32'd1;
                    end
                    state_next.skip_remaining = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        state_next.phase = PH_OPCODE;
                    end
                end
                default:
                begin
                    // Opcode expected; unused phase codes behave the same way.
                    state_next.phase = PH_OPCODE;
                    unique case (stream_byte)
                        OP_SKIP_ARG:  state_next.phase = PH_ARG31;
                        OP_WRITE_A:   state_next.phase = PH_A0_ADDR;
                        OP_WRITE_B:   state_next.phase = PH_B4_ADDR;
                        OP_WAIT_N:    state_next.phase = PH_W61_LO;
                        OP_DATA_BLOCK:
                        begin
                            state_next.phase          = PH_BLK_HDR;
                            state_next.arg_position   = 3'd0;
                            state_next.skip_remaining = 32'd0;
                        end
                        OP_WAIT_NTSC:
                        begin
                            result_valid        = 1'b1;
                            result.kind         = EV_WAIT;
                            result.wait_samples = WAIT_NTSC_SAMPLES;
                        end
                        OP_WAIT_PAL:
                        begin
                            result_valid        = 1'b1;
                            result.kind         = EV_WAIT;
                            result.wait_samples = WAIT_PAL_SAMPLES;
                        end
                        OP_END:
                        begin
                            state_next.halted = 1'b1;
                            result_valid      = 1'b1;
                            result.kind       = EV_END;
                        end
                        default:
                        begin
                            result_valid = 1'b1;
                            if (stream_byte[7:4] == OP_WAIT_SHORT)
                            begin
                                result.kind         = EV_WAIT;
                                result.wait_samples = {12'd0, stream_byte[3:0]} + 16'd1;
                            end
                            else
                            begin
                                state_next.halted = 1'b1;
                                result.kind       = EV_UNKNOWN;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/vgmcbp_checker.sv =====
`default_nettype none

module vgmcbp_checker
    import vgmcbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  event_kind,
    input  logic        chip_index,
    input  logic [7:0]  reg_address,
    input  logic [7:0]  reg_value,
    input  logic [15:0] wait_samples
);

    logic stopped_reg;

    // Set once an end or unknown item has been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg <= 1'b0;
        end
        else if (out_valid && out_ready &&
                 (event_kind == EV_END || event_kind == EV_UNKNOWN))
        begin
            stopped_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
                                    $stable(wait_samples) && $stable(reg_value))
        else $error("output item changed while stalled");

    a_no_item_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> !out_valid)
        else $error("item delivered after end of stream");

    a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_WAIT |-> wait_samples != 16'd0)
        else $error("zero wait delivered");

    a_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_WRITE |->
            chip_index == 1'b0 && reg_address == 8'd0 && reg_value == 8'd0)
        else $error("write fields set on a non-write item");

    a_second_chip_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_WRITE && chip_index |->
            reg_address[7] == 1'b0 && wait_samples == 16'd0)
        else $error("second chip write with wide address or wait count");

endmodule

bind vgm_command_byte_parser_unit vgmcbp_checker u_vgmcbp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .chip_index   (chip_index),
    .reg_address  (reg_address),
    .reg_value    (reg_value),
    .wait_samples (wait_samples)
);

`default_nettype wire

// ===== tb/vgm_command_byte_parser_unit_test.sv =====
`timescale 1ns / 100ps

module vgm_command_byte_parser_unit_test;
    import vgmcbp_pkg::*;

    // No accepted item on either side for this many cycles ends the run.
    // The longest honest pause is a long input gap, a long output stall or
    // the drain before a configuration write.
    localparam int QUIET_LIMIT = 2000;
    // The result of a byte shows after the input and result registers, and a
    // byte that yields nothing may still be in flight when the queue empties.
    localparam int DRAIN_CYCLES = 6;
    localparam int END_WAIT_LIMIT = 1000;
    localparam int MAX_PRINTED = 50;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic        cfg_write_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  stream_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  event_kind;
    logic        chip_index;
    logic [7:0]  reg_address;
    logic [7:0]  reg_value;
    logic [15:0] wait_samples;

    // The scoreboard keeps its own copy of the parser state and the chip
    // family selection, works out what each accepted byte should produce,
    // and matches the results of the block against that in order.
    class byte_parse_scoreboard;
        bit             family;
        phase_t         phase;
        logic [2:0]     arg_pos;
        logic [7:0]     held_addr;
        logic [7:0]     held_lo;
        logic [31:0]    skip_left;
        bit             halted;
        parser_result_t awaited_events[$];
        int             mismatches;

        function new();
            family     = 1'b0;
            phase      = PH_OPCODE;
            arg_pos    = '0;
            held_addr  = '0;
            held_lo    = '0;
            skip_left  = '0;
            halted     = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited_events.size();
        endfunction

        // Advances the parser by one byte; returns 1 when the byte yields an
        // event, which is then left in ev with unused fields at zero.
        function bit parse_byte(input logic [7:0] b, output parser_result_t ev);
            ev = '0;
            if (halted)
                return 1'b0;
            case (phase)
                PH_ARG31:
                begin
                    phase = PH_OPCODE;
                    return 1'b0;
                end
                PH_A0_ADDR:
                begin
                    held_addr = b;
                    phase = PH_A0_DATA;
                    return 1'b0;
                end
                PH_A0_DATA:
                begin
                    phase = PH_OPCODE;
                    if (family != 1'b0)
                        return 1'b0;
                    ev.kind        = EV_WRITE;
                    ev.chip_index  = held_addr[7];
                    ev.reg_address = {1'b0, held_addr[6:0]};
                    ev.reg_value   = b;
                    return 1'b1;
                end
                PH_B4_ADDR:
                begin
                    held_addr = b;
                    phase = PH_B4_DATA;
                    return 1'b0;
                end
                PH_B4_DATA:
                begin
                    phase = PH_OPCODE;
                    if (family != 1'b1)
                        return 1'b0;
                    ev.kind        = EV_WRITE;
                    ev.reg_address = held_addr;
                    ev.reg_value   = b;
                    return 1'b1;
                end
                PH_W61_LO:
                begin
                    held_lo = b;
                    phase = PH_W61_HI;
                    return 1'b0;
                end
                PH_W61_HI:
                begin
                    phase = PH_OPCODE;
                    if ({b, held_lo} == 16'd0)
                        return 1'b0;
                    ev.kind         = EV_WAIT;
                    ev.wait_samples = {b, held_lo};
                    return 1'b1;
                end
                PH_BLK_HDR:
                begin
                    if (arg_pos >= BLK_LEN_B0 && arg_pos <= BLK_LEN_B3)
                        skip_left |= {24'd0, b} << (8 * int'(arg_pos - BLK_LEN_B0));
                    if (arg_pos >= BLK_HDR_LAST) begin
                        arg_pos = '0;
                        phase = (skip_left == 0) ? PH_OPCODE : PH_BLK_SKIP;
                    end
                    else begin
                        arg_pos = arg_pos + 3'd1;
                    end
                    return 1'b0;
                end
                PH_BLK_SKIP:
                begin
                    if (skip_left > 0)
                        skip_left = skip_left - 32'd1;
                    if (skip_left == 0)
                        phase = PH_OPCODE;
                    return 1'b0;
                end
                default:
                begin
                end
            endcase

            phase = PH_OPCODE;
            case (b)
                OP_SKIP_ARG:
                begin
                    phase = PH_ARG31;
                    return 1'b0;
                end
                OP_WRITE_A:
                begin
                    phase = PH_A0_ADDR;
                    return 1'b0;
                end
                OP_WRITE_B:
                begin
                    phase = PH_B4_ADDR;
                    return 1'b0;
                end
                OP_WAIT_N:
                begin
                    phase = PH_W61_LO;
                    return 1'b0;
                end
                OP_DATA_BLOCK:
                begin
                    phase = PH_BLK_HDR;
                    arg_pos = '0;
                    skip_left = '0;
                    return 1'b0;
                end
                OP_WAIT_NTSC:
                begin
                    ev.kind = EV_WAIT;
                    ev.wait_samples = WAIT_NTSC_SAMPLES;
                    return 1'b1;
                end
                OP_WAIT_PAL:
                begin
                    ev.kind = EV_WAIT;
                    ev.wait_samples = WAIT_PAL_SAMPLES;
                    return 1'b1;
                end
                OP_END:
                begin
                    halted = 1'b1;
                    ev.kind = EV_END;
                    return 1'b1;
                end
                default:
                begin
                end
            endcase
            if (b[7:4] == OP_WAIT_SHORT) begin
                ev.kind = EV_WAIT;
                ev.wait_samples = {12'd0, b[3:0]} + 16'd1;
                return 1'b1;
            end
            halted = 1'b1;
            ev.kind = EV_UNKNOWN;
            return 1'b1;
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("%0t ERROR: %s", $realtime, what);
        endtask

        function void note_byte(input logic [7:0] b);
            parser_result_t ev;
            if (parse_byte(b, ev))
                awaited_events.push_back(ev);
        endfunction

        task check_result(input parser_result_t got);
            parser_result_t want;
            if (awaited_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d chip=%0d addr=%h val=%h wait=%0d",
                    got.kind, got.chip_index, got.reg_address, got.reg_value,
                    got.wait_samples));
                return;
            end
            want = awaited_events.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("event_kind %0d, wanted %0d", got.kind, want.kind));
            if (got.chip_index !== want.chip_index)
                report_mismatch($sformatf("chip_index %0d, wanted %0d",
                    got.chip_index, want.chip_index));
            if (got.reg_address !== want.reg_address)
                report_mismatch($sformatf("reg_address %h, wanted %h",
                    got.reg_address, want.reg_address));
            if (got.reg_value !== want.reg_value)
                report_mismatch($sformatf("reg_value %h, wanted %h",
                    got.reg_value, want.reg_value));
            if (got.wait_samples !== want.wait_samples)
                report_mismatch($sformatf("wait_samples %0d, wanted %0d",
                    got.wait_samples, want.wait_samples));
        endtask

        task flag_leftovers();
            while (awaited_events.size() != 0) begin
                void'(awaited_events.pop_front());
                report_mismatch("expected result never arrived");
            end
        endtask
    endclass

    byte_parse_scoreboard sb;
    parser_result_t       seen_result;
    int                   bytes_sent;
    int                   quiet_cycles;
    // While calm is set neither side inserts gaps or stalls.
    bit                   calm;

    vgm_command_byte_parser_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .stream_byte    (stream_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .chip_index     (chip_index),
        .reg_address    (reg_address),
        .reg_value      (reg_value),
        .wait_samples   (wait_samples)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Gap lengths: half of all draws give no gap, most of the rest are short
    // and the odd one is long enough to back the pipeline up completely.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Any byte that is not a known opcode; it stops the parser for good.
    function automatic logic [7:0] pick_unknown_opcode();
        logic [7:0] b;
        do
            b = rand_byte();
        while (b == OP_SKIP_ARG || b == OP_WRITE_A || b == OP_WRITE_B
               || b == OP_WAIT_N || b == OP_WAIT_NTSC || b == OP_WAIT_PAL
               || b == OP_END || b == OP_DATA_BLOCK || b[7:4] == OP_WAIT_SHORT);
        return b;
    endfunction

    // Offers one byte, holds it until it is taken, then perhaps idles.
    task automatic send_byte(input logic [7:0] b);
        int g;
        @(negedge clk);
        in_valid    <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
        g = pick_gap();
        repeat (g)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_data_block(input int unsigned len);
        send_byte(OP_DATA_BLOCK);
        // The marker byte by convention has the same value as the end opcode.
        send_byte(OP_END);
        send_byte(rand_byte());
        for (int i = 0; i < 4; i++)
            send_byte(8'(len >> (8 * i)));
        repeat (len)
            send_byte(rand_byte());
    endtask

    // Changes the chip family only once every item has passed through, so
    // that the new selection cannot reach a byte that is still in flight.
    task automatic set_family(input bit fam);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= fam;
        @(posedge clk);
        sb.family = fam;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // One well-formed command with random content, or now and then a write
    // whose arguments are opcode values, which must still be taken as data.
    task automatic random_command();
        int r;
        int unsigned cnt;
        logic [7:0] lookalike [6];
        lookalike = '{OP_END, OP_DATA_BLOCK, OP_WAIT_N, OP_WRITE_A, OP_WRITE_B, 8'hFF};
        r = $urandom_range(0, 99);
        if (r < 22) begin
            send_byte(OP_WRITE_A);
            send_byte(rand_byte());
            send_byte(rand_byte());
        end
        else if (r < 44) begin
            send_byte(OP_WRITE_B);
            send_byte(rand_byte());
            send_byte(rand_byte());
        end
        else if (r < 56) begin
            case ($urandom_range(0, 5))
                0: cnt = 0;
                1: cnt = 16'hFFFF;
                default: cnt = $urandom_range(0, 16'hFFFF);
            endcase
            send_byte(OP_WAIT_N);
            send_byte(8'(cnt));
            send_byte(8'(cnt >> 8));
        end
        else if (r < 62) begin
            send_byte(OP_WAIT_NTSC);
        end
        else if (r < 68) begin
            send_byte(OP_WAIT_PAL);
        end
        else if (r < 78) begin
            send_byte({OP_WAIT_SHORT, 4'($urandom_range(0, 15))});
        end
        else if (r < 83) begin
            send_byte(OP_SKIP_ARG);
            send_byte(rand_byte());
        end
        else if (r < 89) begin
            // Short blocks only; the long one is sent once in the directed part.
            send_data_block($urandom_range(0, 6));
        end
        else begin
            send_byte($urandom_range(0, 1) ? OP_WRITE_A : OP_WRITE_B);
            send_byte(lookalike[$urandom_range(0, 5)]);
            send_byte(lookalike[$urandom_range(0, 5)]);
        end
    endtask

    task automatic random_commands(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
            random_command();
    endtask

    // The output side takes results at random, with stalls of the same shape
    // as the input gaps.
    initial
    begin
        int g;
        forever
        begin
            g = pick_gap();
            if (g == 0) begin
                @(negedge clk);
                out_ready <= 1'b1;
            end
            else begin
                repeat (g)
                begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    // Results are sampled at the rising edge, where out_valid and out_ready
    // still hold the values that the edge acts upon.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            seen_result.kind         = event_kind_t'(event_kind);
            seen_result.chip_index   = chip_index;
            seen_result.reg_address  = reg_address;
            seen_result.reg_value    = reg_value;
            seen_result.wait_samples = wait_samples;
            sb.check_result(seen_result);
        end
    end

    // Watchdog: a hung handshake on either side shows as a long run of
    // cycles in which no item moves.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int waited;
        sb             = new();
        bytes_sent     = 0;
        quiet_cycles   = 0;
        calm           = 1'b0;
        waited         = 0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        in_valid       = 1'b0;
        stream_byte    = 8'd0;
        out_ready      = 1'b0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the first family selected: a write to the
        // second chip at register zero, a second-family write that must be
        // dropped, a zero wait that yields nothing, the largest wait, the
        // fixed waits, both ends of the short waits, an ignored argument that
        // looks like an opcode, an empty data block and one long enough to
        // need the second length byte.
        set_family(1'b0);
        send_byte(OP_WRITE_A);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(OP_WRITE_B);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(OP_WAIT_N);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(OP_WAIT_N);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(OP_WAIT_NTSC);
        send_byte(OP_WAIT_PAL);
        send_byte({OP_WAIT_SHORT, 4'h0});
        send_byte({OP_WAIT_SHORT, 4'hF});
        send_byte(OP_SKIP_ARG);
        send_byte(OP_WRITE_A);
        send_data_block(0);
        send_data_block($urandom_range(256, 262));

        // Random phases alternate the family; one runs with no idling.
        set_family(1'b1);
        random_commands(30);
        set_family(1'b0);
        calm = 1'b1;
        random_commands(20);
        calm = 1'b0;
        set_family(1'b1);
        random_commands(30);
        set_family(1'b0);
        random_commands(30);

        // The parser stops for good on the end command or an unknown opcode,
        // so only one of them can be seen per run; the bytes after it must
        // all be swallowed without a result.
        if ($urandom_range(0, 1))
            send_byte(OP_END);
        else
            send_byte(pick_unknown_opcode());
        repeat (16)
            send_byte(rand_byte());
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending() != 0 && waited < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        sb.flag_leftovers();

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/vgmcbp_pkg.sv
src/vgmcbp_step.sv
src/vgm_command_byte_parser_unit.sv
src/vgmcbp_checker.sv
tb/vgm_command_byte_parser_unit_test.sv
